@@ rtl/apd_pkg.sv @@
// ----------------------------------------------------------------------------
// apd_pkg
// Shared types and constants for the addressed packet deframer: frame phases,
// byte roles, counter widths and the state and result bundles.
// ----------------------------------------------------------------------------
package apd_pkg;

  localparam int unsigned MAX_PAYLOAD = 20;
  localparam int unsigned CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ROLE_W      = 4;
  localparam int unsigned PIDX_W      = 5;

  localparam logic [BYTE_W-1:0] MAX_PAYLOAD_B = BYTE_W'(MAX_PAYLOAD);
  localparam logic [BYTE_W-1:0] NODE_ADDR_RST = 8'd2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // One-hot frame phase
  typedef enum logic [7:0] {
    PH_HUNT    = 8'b0000_0001,
    PH_SOURCE  = 8'b0000_0010,
    PH_SEQ     = 8'b0000_0100,
    PH_CMD     = 8'b0000_1000,
    PH_CHAN    = 8'b0001_0000,
    PH_SIZE    = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_CHECK   = 8'b1000_0000
  } phase_t;

  typedef enum logic [ROLE_W-1:0] {
    ROLE_IGNORED = 4'd0,
    ROLE_DEST    = 4'd1,
    ROLE_SOURCE  = 4'd2,
    ROLE_SEQ     = 4'd3,
    ROLE_CMD     = 4'd4,
    ROLE_CHAN    = 4'd5,
    ROLE_SIZE    = 4'd6,
    ROLE_PAYLOAD = 4'd7,
    ROLE_CHECK   = 4'd8
  } role_t;

  typedef struct packed {
    phase_t phase;
    cnt_t   left;
    cnt_t   count;
    byte_t  sum;
  } frame_state_t;

  typedef struct packed {
    role_t              role;
    byte_t              value;
    logic [PIDX_W-1:0]  pidx;
    logic               fend;
    logic               good;
    logic               serr;
  } frame_result_t;

endpackage

@@ rtl/apd_step.sv @@
// ----------------------------------------------------------------------------
// apd_step
// Next-state and result logic for one received byte of the deframer.
// ----------------------------------------------------------------------------
module apd_step (
  input  apd_pkg::frame_state_t  state,
  input  apd_pkg::byte_t         rx_byte,
  input  apd_pkg::byte_t         node_address,
  output apd_pkg::frame_state_t  state_nxt,
  output apd_pkg::frame_result_t result
);
  import apd_pkg::*;

  cnt_t left_dec;

  assign left_dec = state.left - cnt_t'(1);

  always_comb begin
    state_nxt    = state;
    result.role  = ROLE_IGNORED;
    result.value = rx_byte;
    result.pidx  = '0;
    result.fend  = 1'b0;
    result.good  = 1'b0;
    result.serr  = 1'b0;

    case (state.phase)
      PH_SOURCE, PH_SEQ, PH_CMD, PH_CHAN: begin
        state_nxt.sum = state.sum + rx_byte;
        case (state.phase)
          PH_SOURCE: begin
            result.role     = ROLE_SOURCE;
            state_nxt.phase = PH_SEQ;
          end
          PH_SEQ: begin
            result.role     = ROLE_SEQ;
            state_nxt.phase = PH_CMD;
          end
          PH_CMD: begin
            result.role     = ROLE_CMD;
            state_nxt.phase = PH_CHAN;
          end
          default: begin
            result.role     = ROLE_CHAN;
            state_nxt.phase = PH_SIZE;
          end
        endcase
      end
      PH_SIZE: begin
        result.role     = ROLE_SIZE;
        state_nxt.sum   = state.sum + rx_byte;
        state_nxt.count = '0;
        if (rx_byte > MAX_PAYLOAD_B) begin
          // oversized: abort and resume hunting
          result.serr     = 1'b1;
          result.fend     = 1'b1;
          state_nxt.left  = '0;
          state_nxt.sum   = '0;
          state_nxt.phase = PH_HUNT;
        end else if (rx_byte == '0) begin
          state_nxt.left  = '0;
          state_nxt.phase = PH_CHECK;
        end else begin
          state_nxt.left  = rx_byte[CNT_W-1:0];
          state_nxt.phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        result.role     = ROLE_PAYLOAD;
        result.pidx     = PIDX_W'(state.count);
        state_nxt.sum   = state.sum + rx_byte;
        state_nxt.count = state.count + cnt_t'(1);
        state_nxt.left  = left_dec;
        if (left_dec == '0) begin
          state_nxt.phase = PH_CHECK;
        end
      end
      PH_CHECK: begin
        result.role     = ROLE_CHECK;
        result.fend     = 1'b1;
        result.good     = (rx_byte == ~state.sum);
        state_nxt.sum   = '0;
        state_nxt.left  = '0;
        state_nxt.count = '0;
        state_nxt.phase = PH_HUNT;
      end
      default: begin
        // hunting: wait for our own address
        state_nxt.phase = PH_HUNT;
        if (rx_byte == node_address) begin
          result.role     = ROLE_DEST;
          state_nxt.sum   = rx_byte;
          state_nxt.left  = '0;
          state_nxt.count = '0;
          state_nxt.phase = PH_SOURCE;
        end
      end
    endcase
  end

endmodule

@@ rtl/addressed_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// addressed_packet_deframer
// Receive-side deframer for addressed link frames with an additive checksum.
// ----------------------------------------------------------------------------
// Each received byte is one request on the in_ channel and gives exactly one
// result on the out_ channel, tagged with its role in the frame. While
// hunting, bytes are reported as ignored until one equals cfg_node_address
// (reset value 2); that byte opens a frame, followed by source, sequence,
// command, channel and size bytes, then size payload bytes, then a checksum
// byte. The frame is good when the checksum is the one's complement of the
// 8-bit sum of all bytes from the destination to the last payload byte. A
// size of zero goes straight to the checksum; a size above MAX_PAYLOAD flags
// size_error, ends the frame and resumes hunting. A request passes through
// an input register and a result register, and one request can be taken
// every cycle; throughput is limited only by out_ready. cfg_ready is
// always high; write the address only while idle.
// ----------------------------------------------------------------------------
module addressed_packet_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [apd_pkg::BYTE_W-1:0]   cfg_node_address,
  // received bytes
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [apd_pkg::BYTE_W-1:0]   in_rx_byte,
  // classified bytes
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [apd_pkg::ROLE_W-1:0]   out_byte_role,
  output logic [apd_pkg::BYTE_W-1:0]   out_byte_value,
  output logic [apd_pkg::PIDX_W-1:0]   out_payload_index,
  output logic                         out_frame_end,
  output logic                         out_checksum_good,
  output logic                         out_size_error
);
  import apd_pkg::*;

  byte_t         node_addr_r;
  logic          in_valid_r;
  byte_t         in_byte_r;
  frame_state_t  state_r;
  frame_state_t  state_nxt;
  logic          out_valid_r;
  frame_result_t out_res_r;
  frame_result_t res_nxt;
  logic          out_free;
  logic          advance;

  // The result register frees up when empty or being drained this cycle.
  assign out_free  = !out_valid_r || out_ready;
  // Advance the held request into the result register.
  assign advance   = in_valid_r && out_free;
  assign in_ready  = !in_valid_r || out_free;
  assign cfg_ready = 1'b1;

  apd_step u_step (
    .state        (state_r),
    .rx_byte      (in_byte_r),
    .node_address (node_addr_r),
    .state_nxt    (state_nxt),
    .result       (res_nxt)
  );

  // Node address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r <= NODE_ADDR_RST;
    end else if (cfg_valid) begin
      node_addr_r <= cfg_node_address;
    end
  end

  // Input register: capture a request whenever the stage is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Frame state: update only as a byte moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase <= PH_HUNT;
      state_r.left  <= '0;
      state_r.count <= '0;
      state_r.sum   <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte_role     = out_res_r.role;
  assign out_byte_value    = out_res_r.value;
  assign out_payload_index = out_res_r.pidx;
  assign out_frame_end     = out_res_r.fend;
  assign out_checksum_good = out_res_r.good;
  assign out_size_error    = out_res_r.serr;

endmodule

@@ dv/addressed_packet_deframer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// addressed_packet_deframer_tb
// Self-checking bench for the addressed packet deframer. Streams link bytes
// through the request channel: directed tests first, then random traffic
// under several node addresses. Classifies each accepted byte in a local
// frame tracker and compares every returned result with the oldest
// prediction, with random idling on both sides and one long receiver hold.
// ----------------------------------------------------------------------------
module addressed_packet_deframer_tb;
  import apd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        cfg_valid        = 1'b0;
  logic        cfg_ready;
  byte_t       cfg_node_address = '0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  byte_t       in_rx_byte       = '0;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic [ROLE_W-1:0] out_byte_role;
  byte_t             out_byte_value;
  logic [PIDX_W-1:0] out_payload_index;
  logic              out_frame_end;
  logic              out_checksum_good;
  logic              out_size_error;

  addressed_packet_deframer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_node_address  (cfg_node_address),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte_role     (out_byte_role),
    .out_byte_value    (out_byte_value),
    .out_payload_index (out_payload_index),
    .out_frame_end     (out_frame_end),
    .out_checksum_good (out_checksum_good),
    .out_size_error    (out_size_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Frame tracker: the bench's own view of where the block is in a frame.
  byte_t  node_addr = NODE_ADDR_RST;
  phase_t rx_phase  = PH_HUNT;
  cnt_t   rx_left   = '0;
  cnt_t   rx_count  = '0;
  byte_t  rx_sum    = '0;

  // Classifications still owed by the block, oldest first.
  frame_result_t expected_results[$];

  int unsigned fail_count       = 0;
  int unsigned frame_bytes_sent = 0;  // requests that were not ignored
  int unsigned cycle_count      = 0;
  int unsigned hold_request     = 0;  // receiver hold-off asked by a test
  bit          idling           = 1'b1;

  // Classify one received byte and advance the frame tracker.
  function automatic frame_result_t classify_byte(input byte_t b);
    frame_result_t r;
    r       = '0;
    r.role  = ROLE_IGNORED;
    r.value = b;
    case (rx_phase)
      PH_HUNT: begin
        // Only the node address opens a frame; everything else is dropped.
        if (b == node_addr) begin
          r.role   = ROLE_DEST;
          rx_sum   = b;
          rx_left  = '0;
          rx_count = '0;
          rx_phase = PH_SOURCE;
        end
      end
      PH_SOURCE: begin
        r.role   = ROLE_SOURCE;
        rx_sum   = rx_sum + b;
        rx_phase = PH_SEQ;
      end
      PH_SEQ: begin
        r.role   = ROLE_SEQ;
        rx_sum   = rx_sum + b;
        rx_phase = PH_CMD;
      end
      PH_CMD: begin
        r.role   = ROLE_CMD;
        rx_sum   = rx_sum + b;
        rx_phase = PH_CHAN;
      end
      PH_CHAN: begin
        r.role   = ROLE_CHAN;
        rx_sum   = rx_sum + b;
        rx_phase = PH_SIZE;
      end
      PH_SIZE: begin
        r.role   = ROLE_SIZE;
        rx_sum   = rx_sum + b;
        rx_count = '0;
        if (b > MAX_PAYLOAD_B) begin
          // Oversized: flag it, close the frame and go back to hunting.
          r.serr   = 1'b1;
          r.fend   = 1'b1;
          rx_left  = '0;
          rx_sum   = '0;
          rx_phase = PH_HUNT;
        end else if (b == '0) begin
          // Empty payload: the next byte is the checksum.
          rx_left  = '0;
          rx_phase = PH_CHECK;
        end else begin
          rx_left  = cnt_t'(b);
          rx_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.role   = ROLE_PAYLOAD;
        r.pidx   = PIDX_W'(rx_count);
        rx_sum   = rx_sum + b;
        rx_count = rx_count + cnt_t'(1);
        rx_left  = rx_left - cnt_t'(1);
        if (rx_left == '0) rx_phase = PH_CHECK;
      end
      default: begin
        r.role   = ROLE_CHECK;
        r.fend   = 1'b1;
        r.good   = (b == ~rx_sum);
        rx_sum   = '0;
        rx_left  = '0;
        rx_count = '0;
        rx_phase = PH_HUNT;
      end
    endcase
    return r;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned gap_length();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Offer one byte as a request and record its classification on acceptance.
  // Valid is only lowered when a pause follows, so back-to-back requests keep
  // it high across the edge.
  task automatic send_byte(input byte_t b);
    frame_result_t want;
    int unsigned   gap;
    gap = (idling && $urandom_range(0, 99) < 35) ? gap_length() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    want = classify_byte(b);
    if (want.role != ROLE_IGNORED) frame_bytes_sent++;
    expected_results.push_back(want);
  endtask

  // Send one frame from the hunting state; corrupt spoils its checksum. Drop
  // out of any unfinished frame first with bytes that cannot open a new one.
  task automatic send_frame(input byte_t size_b, input bit corrupt, input bit addr_fill);
    byte_t       sum;
    byte_t       b;
    int unsigned body;
    while (rx_phase != PH_HUNT) begin
      do b = byte_t'($urandom); while (b == node_addr);
      send_byte(b);
    end
    sum  = node_addr;
    send_byte(node_addr);
    body = (size_b > MAX_PAYLOAD_B) ? 0 : size_b;
    // Four header bytes, the size byte, then the payload.
    for (int i = 0; i < 5 + body; i++) begin
      if (i == 4) b = size_b;
      else b = addr_fill ? node_addr : byte_t'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    if (size_b <= MAX_PAYLOAD_B) begin
      b = ~sum;
      if (corrupt) b = b ^ byte_t'($urandom_range(1, 255));
      send_byte(b);
    end
  endtask

  // Release the request channel and let every owed result come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Reprogram the node address; only done with the block idle.
  task automatic write_node_address(input byte_t addr);
    wait_for_results();
    cfg_valid        <= 1'b1;
    cfg_node_address <= addr;
    do @(posedge clk); while (!cfg_ready);
    node_addr = addr;
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly proper frames with random content, the rest
  // oversized frames, frames cut short and loose line noise.
  task automatic run_traffic(input int unsigned n);
    int unsigned target;
    int unsigned next_toggle;
    int unsigned pick;
    byte_t       size_b;
    target      = frame_bytes_sent + n;
    next_toggle = frame_bytes_sent + 150;
    while (frame_bytes_sent < target) begin
      if (frame_bytes_sent >= next_toggle) begin
        // Choose at random whether the next stretch idles.
        idling      = ($urandom_range(0, 3) != 0);
        next_toggle = frame_bytes_sent + 150;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 9))
          0:       size_b = MAX_PAYLOAD_B;
          1, 2:    size_b = byte_t'($urandom_range(0, MAX_PAYLOAD));
          default: size_b = byte_t'($urandom_range(0, 4));
        endcase
        send_frame(size_b, $urandom_range(0, 3) == 0, $urandom_range(0, 19) == 0);
      end else if (pick < 80) begin
        send_frame(byte_t'($urandom_range(MAX_PAYLOAD + 1, 255)), 1'b0, 1'b0);
      end else if (pick < 90) begin
        // Cut a frame short; what follows lands inside it.
        send_byte(node_addr);
        repeat ($urandom_range(1, 6)) send_byte(byte_t'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(byte_t'($urandom));
      end
    end
  endtask

  task automatic test_ignored_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
  endtask

  task automatic test_zero_size_frame();
    send_frame(8'd0, 1'b0, 1'b0);
  endtask

  task automatic test_oversized_size();
    send_frame(MAX_PAYLOAD_B + 8'd1, 1'b0, 1'b0);
  endtask

  // Address bytes in the header and payload must not restart the frame;
  // close it with a bad checksum.
  task automatic test_address_in_frame();
    send_frame(8'd1, 1'b1, 1'b1);
  endtask

  task automatic test_node_address_extremes();
    write_node_address(8'h00);
    run_traffic(300);
    write_node_address(8'hFF);
    run_traffic(300);
  endtask

  task automatic test_random_traffic();
    repeat (4) begin
      write_node_address(byte_t'($urandom));
      run_traffic(300);
    end
  endtask

  // Hold the receiver off for a long stretch while requests keep coming, so
  // the block fills and stalls its input.
  task automatic test_back_pressure();
    idling       = 1'b0;
    hold_request = 250;
    run_traffic(60);
    idling       = 1'b1;
  endtask

  // Receiver: random stalls, plus any long hold-off a test asks for.
  initial begin : receiver
    int unsigned hold;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold         = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else if (idling && $urandom_range(0, 99) < 20) begin
        out_ready <= 1'b0;
        repeat (gap_length()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker: match each returned byte against the oldest prediction.
  frame_result_t want_now;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: role %0d value %02h", out_byte_role, out_byte_value);
        fail_count++;
      end else begin
        want_now = expected_results.pop_front();
        if (out_byte_role != want_now.role) begin
          $error("byte_role: expected %0d, actual %0d", want_now.role, out_byte_role);
          fail_count++;
        end
        if (out_byte_value != want_now.value) begin
          $error("byte_value: expected %02h, actual %02h", want_now.value, out_byte_value);
          fail_count++;
        end
        if (out_payload_index != want_now.pidx) begin
          $error("payload_index: expected %0d, actual %0d", want_now.pidx,
                 out_payload_index);
          fail_count++;
        end
        if (out_frame_end != want_now.fend) begin
          $error("frame_end: expected %0d, actual %0d", want_now.fend, out_frame_end);
          fail_count++;
        end
        if (out_checksum_good != want_now.good) begin
          $error("checksum_good: expected %0d, actual %0d", want_now.good,
                 out_checksum_good);
          fail_count++;
        end
        if (out_size_error != want_now.serr) begin
          $error("size_error: expected %0d, actual %0d", want_now.serr, out_size_error);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ignored_bytes();
    test_zero_size_frame();
    test_oversized_size();
    test_address_in_frame();
    test_node_address_extremes();
    test_random_traffic();
    test_back_pressure();

    wait_for_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
